// ----- rtl/core/rre_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rre_pkg
// Shared constants, types and helpers of the reaction rate evaluator.
// ----------------------------------------------------------------------------
package rre_pkg;

  localparam int FRAC_BITS = 16;
  localparam int CONC_W    = 32;
  localparam int COEF_W    = 32;
  localparam int TERM_W    = 60;
  localparam int SUM_W     = 64;
  localparam int CFG_IDX_W = 4;

  localparam logic [COEF_W-1:0] RHO0_FIXED = 32'd65536;
  localparam logic [COEF_W-1:0] RHO1_FIXED = 32'd65536;
  localparam logic [COEF_W-1:0] EPS_FIXED  = 32'd65536;

  localparam logic [TERM_W-1:0] TERM_CAP = {TERM_W{1'b1}};
  localparam logic [TERM_W-1:0] FIX_ONE  = TERM_W'(1) << FRAC_BITS;

  // Divider: one quotient bit per stage.
  localparam int DIV_STEPS = TERM_W;
  localparam int NLO_W     = TERM_W - FRAC_BITS;

  // Pipeline depths: input copies up to the second divider, the side band
  // that runs alongside the divider, and the valid line up to the last stage.
  localparam int IB_DEPTH   = 7;
  localparam int SIDE_DEPTH = DIV_STEPS + 1;
  localparam int VLD_DEPTH  = IB_DEPTH + SIDE_DEPTH;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_D      = 4'd0,
    CFG_E      = 4'd1,
    CFG_F      = 4'd2,
    CFG_GAIN   = 4'd3,
    CFG_MU     = 4'd4,
    CFG_NU     = 4'd5,
    CFG_GAMMA  = 4'd6,
    CFG_SUPPLY = 4'd7
  } cfg_reg_t;

  localparam logic signed [SUM_W-1:0] RATE_MAX = 64'sd2147483647;
  localparam logic signed [SUM_W-1:0] RATE_MIN = -64'sd2147483648;

  // Returns {clipped, value} for a signed sum clamped to 32 bits.
  function automatic logic [32:0] clamp_rate(input logic signed [SUM_W-1:0] v);
    logic [32:0] res;
    if (v > RATE_MAX) begin
      res = {1'b1, 32'h7FFF_FFFF};
    end else if (v < RATE_MIN) begin
      res = {1'b1, 32'h8000_0000};
    end else begin
      res = {1'b0, v[31:0]};
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/rre_mul.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rre_mul
// Two-stage fixed-point multiplier: (a * b) >> FRAC_BITS, saturated.
// ----------------------------------------------------------------------------
module rre_mul (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [rre_pkg::TERM_W-1:0] a,
  input  wire logic [rre_pkg::COEF_W-1:0] b,
  output logic      [rre_pkg::TERM_W-1:0] p
);
  import rre_pkg::*;

  logic [2*COEF_W-1:0]               lo_prod;
  logic [TERM_W-COEF_W+COEF_W-1:0]   hi_prod;
  logic [TERM_W+COEF_W-1:0]          full;
  logic                              ovf;

  // The operand is split into two halves so that each multiplier is at most
  // 32 by 32 bits; the halves are recombined in the second stage.
  always_ff @(posedge clk) begin
    if (en) begin
      lo_prod <= a[COEF_W-1:0] * b;
      hi_prod <= a[TERM_W-1:COEF_W] * b;
    end
  end

  assign full = {hi_prod, {COEF_W{1'b0}}} + (TERM_W+COEF_W)'(lo_prod);
  assign ovf  = |full[TERM_W+COEF_W-1:2*COEF_W];

  always_ff @(posedge clk) begin
    if (en) begin
      p <= ovf ? TERM_CAP : TERM_W'(full[2*COEF_W-1:FRAC_BITS]);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/rre_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rre_div
// Pipelined restoring divider: floor(num * 2^FRAC_BITS / den), saturated.
// ----------------------------------------------------------------------------
module rre_div (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [rre_pkg::TERM_W-1:0] num,
  input  wire logic [rre_pkg::TERM_W-1:0] den,
  output logic      [rre_pkg::TERM_W-1:0] quo
);
  import rre_pkg::*;

  typedef struct packed {
    logic              ovf;
    logic [TERM_W-1:0] rem;
    logic [TERM_W-1:0] q;
    logic [NLO_W-1:0]  low;
    logic [TERM_W-1:0] dvs;
  } div_stage_t;

  div_stage_t stg [DIV_STEPS+1];

  function automatic div_stage_t div_step(input div_stage_t s);
    div_stage_t n;
    logic [TERM_W:0] cur;
    logic [TERM_W:0] diff;
    logic            ge;
    cur  = {s.rem, s.low[NLO_W-1]};
    diff = cur - {1'b0, s.dvs};
    ge   = (cur >= {1'b0, s.dvs});
    n     = s;
    n.rem = ge ? diff[TERM_W-1:0] : cur[TERM_W-1:0];
    n.q   = {s.q[TERM_W-2:0], ge};
    n.low = {s.low[NLO_W-2:0], 1'b0};
    return n;
  endfunction

  // The quotient overflows exactly when num >= den * 2^NLO_W; otherwise the
  // top FRAC_BITS of the shifted dividend already lie below the divisor.
  always_ff @(posedge clk) begin
    if (en) begin
      stg[0].ovf <= ({{NLO_W{1'b0}}, num} >= {den, {NLO_W{1'b0}}});
      stg[0].rem <= TERM_W'(num[TERM_W-1:NLO_W]);
      stg[0].q   <= '0;
      stg[0].low <= num[NLO_W-1:0];
      stg[0].dvs <= den;
      for (int k = 1; k <= DIV_STEPS; k++) begin
        stg[k] <= div_step(stg[k-1]);
      end
    end
  end

  assign quo = stg[DIV_STEPS].ovf ? TERM_CAP : stg[DIV_STEPS].q;

endmodule
`default_nettype wire

// ----- rtl/core/reaction_rate_evaluator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// reaction_rate_evaluator
// Time derivatives of the four concentrations of one cell.
// ----------------------------------------------------------------------------
// Usage: one beat on the input channel carries conc_y, conc_a, conc_h and
// conc_s of one cell (unsigned Q16.16). One beat on the output channel later
// carries the four signed Q16.16 rates with the saturated and zero_divisor
// flags. Both channels use valid and stall.
// A new cell is taken every cycle while in_stall is low. The depth is set by
// the two quotient dividers, which resolve one bit per stage over 60 stages.
// The pipeline advances as a whole whenever the result register is empty or
// being taken; while the receiver stalls with a result waiting, everything
// holds and in_stall is raised.
// Reset empties the pipeline and clears all eight coefficients to zero.
// The user must write coefficients through cfg_we/cfg_index/cfg_data only while no
// cell is in flight; the block does not enforce it. Indexes past the last one are ignored.
// ----------------------------------------------------------------------------
module reaction_rate_evaluator (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [rre_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rre_pkg::COEF_W-1:0]    cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [rre_pkg::CONC_W-1:0]    conc_y,
  input  wire logic [rre_pkg::CONC_W-1:0]    conc_a,
  input  wire logic [rre_pkg::CONC_W-1:0]    conc_h,
  input  wire logic [rre_pkg::CONC_W-1:0]    conc_s,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [31:0]                 rate_y,
  output logic signed [31:0]                 rate_a,
  output logic signed [31:0]                 rate_h,
  output logic signed [31:0]                 rate_s,
  output logic                               saturated,
  output logic                               zero_divisor
);
  import rre_pkg::*;

  typedef struct packed {
    logic [CONC_W-1:0] y;
    logic [CONC_W-1:0] a;
    logic [CONC_W-1:0] h;
    logic [CONC_W-1:0] s;
  } conc_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] py;
    logic signed [SUM_W-1:0] pa;
    logic signed [SUM_W-1:0] ph;
    logic signed [SUM_W-1:0] ps;
  } part_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] py;
    logic signed [SUM_W-1:0] pa;
    logic signed [SUM_W-1:0] ph;
    logic signed [SUM_W-1:0] ps;
    logic                    zdiv;
  } side_t;

  logic [COEF_W-1:0] coef_d, coef_e, coef_f, coef_gain;
  logic [COEF_W-1:0] coef_mu, coef_nu, coef_gamma, coef_supply;

  logic                 adv;
  logic [VLD_DEPTH-1:0] vld;
  conc_t                ib [IB_DEPTH];
  part_t                pt [4];
  side_t                sd [SIDE_DEPTH];

  logic [TERM_W-1:0] yy, fy, g1, g2, prod;
  logic [TERM_W-1:0] da, ey, r0y, mua, r1y, nuh, gs, epy, eys;
  logic [TERM_W-1:0] yy3, yy4, yy5, den5;
  logic [TERM_W-1:0] auto_y, auto_y67, quo_a;
  logic [TERM_W:0]   den_sum;

  logic signed [SUM_W-1:0] sum_y, sum_a, sum_h;
  logic [32:0]             cl_y, cl_a, cl_h, cl_s;

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // Coefficient registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_d      <= '0;
      coef_e      <= '0;
      coef_f      <= '0;
      coef_gain   <= '0;
      coef_mu     <= '0;
      coef_nu     <= '0;
      coef_gamma  <= '0;
      coef_supply <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_D:      coef_d      <= cfg_data;
        CFG_E:      coef_e      <= cfg_data;
        CFG_F:      coef_f      <= cfg_data;
        CFG_GAIN:   coef_gain   <= cfg_data;
        CFG_MU:     coef_mu     <= cfg_data;
        CFG_NU:     coef_nu     <= cfg_data;
        CFG_GAMMA:  coef_gamma  <= cfg_data;
        CFG_SUPPLY: coef_supply <= cfg_data;
        default: ;
      endcase
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld       <= {vld[VLD_DEPTH-2:0], in_valid};
      out_valid <= vld[VLD_DEPTH-1];
    end
  end

  // Input register and its copies for operands used further down.
  always_ff @(posedge clk) begin
    if (adv) begin
      ib[0] <= '{y: conc_y, a: conc_a, h: conc_h, s: conc_s};
      for (int k = 1; k < IB_DEPTH; k++) begin
        ib[k] <= ib[k-1];
      end
    end
  end

  // Products from the pipelined fixed-point multipliers.
  rre_mul u_mul_yy  (.clk, .en(adv), .a(TERM_W'(ib[0].y)), .b(ib[0].y), .p(yy));
  rre_mul u_mul_fy  (.clk, .en(adv), .a(yy), .b(coef_f), .p(fy));
  rre_mul u_mul_g1  (.clk, .en(adv), .a(TERM_W'(coef_gain)), .b(ib[0].a), .p(g1));
  rre_mul u_mul_g2  (.clk, .en(adv), .a(g1), .b(ib[2].a), .p(g2));
  rre_mul u_mul_g3  (.clk, .en(adv), .a(g2), .b(ib[4].s), .p(prod));
  rre_mul u_mul_da  (.clk, .en(adv), .a(TERM_W'(coef_d)), .b(ib[0].a), .p(da));
  rre_mul u_mul_ey  (.clk, .en(adv), .a(TERM_W'(coef_e)), .b(ib[0].y), .p(ey));
  rre_mul u_mul_r0y (.clk, .en(adv), .a(TERM_W'(RHO0_FIXED)), .b(ib[0].y), .p(r0y));
  rre_mul u_mul_mua (.clk, .en(adv), .a(TERM_W'(coef_mu)), .b(ib[0].a), .p(mua));
  rre_mul u_mul_r1y (.clk, .en(adv), .a(TERM_W'(RHO1_FIXED)), .b(ib[0].y), .p(r1y));
  rre_mul u_mul_nuh (.clk, .en(adv), .a(TERM_W'(coef_nu)), .b(ib[0].h), .p(nuh));
  rre_mul u_mul_gs  (.clk, .en(adv), .a(TERM_W'(coef_gamma)), .b(ib[0].s), .p(gs));
  rre_mul u_mul_epy (.clk, .en(adv), .a(TERM_W'(EPS_FIXED)), .b(ib[0].y), .p(epy));
  rre_mul u_mul_eys (.clk, .en(adv), .a(epy), .b(ib[2].s), .p(eys));

  assign den_sum = {1'b0, fy} + {1'b0, FIX_ONE};

  // Partial sums of the terms outside the quotients, the autocatalysis operands and the side band.
  always_ff @(posedge clk) begin
    if (adv) begin
      pt[0].py <= $signed(SUM_W'(da)) - $signed(SUM_W'(ey));
      pt[0].pa <= $signed(SUM_W'(r0y)) - $signed(SUM_W'(mua));
      pt[0].ph <= $signed(SUM_W'(r1y)) - $signed(SUM_W'(nuh));
      pt[0].ps <= $signed(SUM_W'(coef_supply)) - $signed(SUM_W'(gs));
      pt[1]    <= pt[0];
      pt[2].py <= pt[1].py;
      pt[2].pa <= pt[1].pa;
      pt[2].ph <= pt[1].ph;
      pt[2].ps <= pt[1].ps - $signed(SUM_W'(eys));
      pt[3]    <= pt[2];

      yy3  <= yy;
      yy4  <= yy3;
      yy5  <= yy4;
      den5 <= (den_sum > {1'b0, TERM_CAP}) ? TERM_CAP : den_sum[TERM_W-1:0];

      sd[0].py   <= pt[3].py;
      sd[0].pa   <= pt[3].pa;
      sd[0].ph   <= pt[3].ph + $signed(SUM_W'(prod));
      sd[0].ps   <= pt[3].ps;
      sd[0].zdiv <= (ib[6].h == '0);
      for (int k = 1; k < SIDE_DEPTH; k++) begin
        sd[k] <= sd[k-1];
      end

      auto_y67 <= auto_y;
    end
  end

  rre_div u_div_y (.clk, .en(adv), .num(yy5), .den(den5), .quo(auto_y));
  rre_div u_div_a (.clk, .en(adv), .num(prod), .den(TERM_W'(ib[6].h)), .quo(quo_a));

  assign sum_y = sd[SIDE_DEPTH-1].py + $signed(SUM_W'(auto_y67));
  assign sum_a = sd[SIDE_DEPTH-1].pa + $signed(SUM_W'(quo_a));
  assign sum_h = sd[SIDE_DEPTH-1].ph;
  assign cl_y  = clamp_rate(sum_y);
  assign cl_a  = clamp_rate(sum_a);
  assign cl_h  = clamp_rate(sum_h);
  assign cl_s  = clamp_rate(sd[SIDE_DEPTH-1].ps);

  // Result register. A zero H forces the A rate to its positive limit.
  always_ff @(posedge clk) begin
    if (adv) begin
      rate_y       <= cl_y[31:0];
      rate_h       <= cl_h[31:0];
      rate_s       <= cl_s[31:0];
      zero_divisor <= sd[SIDE_DEPTH-1].zdiv;
      if (sd[SIDE_DEPTH-1].zdiv) begin
        rate_a    <= 32'sh7FFF_FFFF;
        saturated <= 1'b1;
      end else begin
        rate_a    <= cl_a[31:0];
        saturated <= cl_y[32] | cl_a[32] | cl_h[32] | cl_s[32];
      end
    end
  end

endmodule
`default_nettype wire
